// ===== src/texel_format_to_rgba8_defines.svh =====
// Assertion macros shared by the texel converter.
`ifndef TEXEL_FORMAT_TO_RGBA8_DEFINES_SVH
`define TEXEL_FORMAT_TO_RGBA8_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define TFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define TFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define TFR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/tfr_pkg.sv =====
package tfr_pkg;

    // source_format codes; 8..15 are unsupported
    localparam logic [3:0] FMT_BGRA   = 4'd0;
    localparam logic [3:0] FMT_RGBA   = 4'd1;
    localparam logic [3:0] FMT_ABGR   = 4'd2;
    localparam logic [3:0] FMT_ARGB   = 4'd3;
    localparam logic [3:0] FMT_BGR    = 4'd4;
    localparam logic [3:0] FMT_RGB    = 4'd5;
    localparam logic [3:0] FMT_R5G6B5 = 4'd6;
    localparam logic [3:0] FMT_P8     = 4'd7;

    localparam logic [3:0] FMT_RESET  = FMT_RGBA;

    localparam logic CMD_CONVERT   = 1'b0;
    localparam logic CMD_PAL_WRITE = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       format_error;
    } t_rgba;

    // floor(v*255/31) = 8v + floor(7v/31); the second term counts thresholds
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [2:0] q;
        q = 3'(v >= 5'd5)  + 3'(v >= 5'd9)  + 3'(v >= 5'd14) + 3'(v >= 5'd18)
          + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
        return {v, 3'b000} + {5'b00000, q};
    endfunction

    // floor(v*255/63) = 4v + floor(v/21)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] q;
        q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
        return {v, 2'b00} + {6'b000000, q};
    endfunction

endpackage

// ===== src/tfr_palette.sv =====
module tfr_palette
    import tfr_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int ADDR_W          = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [31:0]       i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [31:0]       o_rd_data
);

    logic [31:0] r_mem [0:PALETTE_ENTRIES-1];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/tfr_convert.sv =====
module tfr_convert
    import tfr_pkg::*;
(
    input  logic [3:0]  i_format,
    input  logic [31:0] i_texel_word,
    input  logic        i_pal_hit,
    input  logic [31:0] i_pal_data,
    output t_rgba       o_pixel
);

    logic [7:0] b0, b1, b2, b3;

    assign b0 = i_texel_word[7:0];
    assign b1 = i_texel_word[15:8];
    assign b2 = i_texel_word[23:16];
    assign b3 = i_texel_word[31:24];

    always_comb begin
        o_pixel = '0;
        case (i_format)
            FMT_BGRA: begin
                o_pixel.red   = b2;
                o_pixel.green = b1;
                o_pixel.blue  = b0;
                o_pixel.alpha = b3;
            end
            FMT_RGBA: begin
                o_pixel.red   = b0;
                o_pixel.green = b1;
                o_pixel.blue  = b2;
                o_pixel.alpha = b3;
            end
            FMT_ABGR: begin
                o_pixel.red   = b3;
                o_pixel.green = b2;
                o_pixel.blue  = b1;
                o_pixel.alpha = b0;
            end
            FMT_ARGB: begin
                o_pixel.red   = b1;
                o_pixel.green = b2;
                o_pixel.blue  = b3;
                o_pixel.alpha = b0;
            end
            FMT_BGR: begin
                o_pixel.red   = b2;
                o_pixel.green = b1;
                o_pixel.blue  = b0;
            end
            FMT_RGB: begin
                o_pixel.red   = b0;
                o_pixel.green = b1;
                o_pixel.blue  = b2;
            end
            FMT_R5G6B5: begin
                o_pixel.red   = expand5(i_texel_word[15:11]);
                o_pixel.green = expand6(i_texel_word[10:5]);
                o_pixel.blue  = expand5(i_texel_word[4:0]);
                o_pixel.alpha = 8'hff;
            end
            FMT_P8: begin
                // index past the palette gives black, transparent
                if (i_pal_hit) begin
                    o_pixel.red   = i_pal_data[23:16];
                    o_pixel.green = i_pal_data[15:8];
                    o_pixel.blue  = i_pal_data[7:0];
                    o_pixel.alpha = i_pal_data[31:24];
                end
            end
            default: begin
                o_pixel.format_error = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/texel_format_to_rgba8.sv =====
// Texel format converter: one source texel in, one RGBA8888 pixel out.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data) sets source_format;
// it is always ready and is to be written only while the block is idle.
// Input channel (i_in_valid/o_in_ready) carries a command: a convert beat
// yields one output beat, a palette-write beat fills one palette entry and
// yields nothing. Output channel is o_out_valid/i_out_ready.
// A convert beat is registered in stage one, then in the output register.
// Throughput: one beat per cycle unless the receiver stalls; each beat makes
// at most one palette access, and the read is registered in stage one.
// A palette write followed in the very next cycle by a P8 read of the same
// entry returns the new data.
// Reset sets source_format to RGBA and empties both pipeline stages; the
// palette is not cleared and needs no clearing pass, so the input is ready
// straight after reset. Unwritten entries read as undefined.
// When the receiver stalls, the output register holds its beat, stage one
// holds too, and o_in_ready drops once stage one is full.
`include "texel_format_to_rgba8_defines.svh"

module texel_format_to_rgba8
    import tfr_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [31:0] i_texel_word,
    input  logic [7:0]  i_palette_index,
    input  logic [31:0] i_palette_entry,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_format_error
);

    localparam int         ADDR_W    = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] ENTRY_LIM = 9'(PALETTE_ENTRIES);

    logic [3:0]  r_format;
    logic        r_s1_valid;
    logic [31:0] r_s1_word;
    logic        r_s1_hit;
    logic        r_out_valid;
    t_rgba       r_out;

    logic        in_accept;
    logic        s1_adv;
    logic        wr_hit;
    logic        rd_hit;
    logic        conv_beat;
    logic [31:0] pal_data;
    t_rgba       pixel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_RESET;
        end else if (i_cfg_valid) begin
            r_format <= i_cfg_data;
        end
    end

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;
    assign conv_beat  = in_accept && (i_command == CMD_CONVERT);

    assign wr_hit = {1'b0, i_palette_index} < ENTRY_LIM;
    assign rd_hit = {1'b0, i_texel_word[7:0]} < ENTRY_LIM;

    tfr_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .ADDR_W          (ADDR_W)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (in_accept && (i_command == CMD_PAL_WRITE) && wr_hit),
        .i_wr_addr (i_palette_index[ADDR_W-1:0]),
        .i_wr_data (i_palette_entry),
        .i_rd_en   (conv_beat && rd_hit),
        .i_rd_addr (i_texel_word[ADDR_W-1:0]),
        .o_rd_data (pal_data)
    );

    // stage one: texel and palette read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= conv_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (conv_beat) begin
            r_s1_word <= i_texel_word;
            r_s1_hit  <= rd_hit;
        end
    end

    tfr_convert u_convert (
        .i_format     (r_format),
        .i_texel_word (r_s1_word),
        .i_pal_hit    (r_s1_hit),
        .i_pal_data   (pal_data),
        .o_pixel      (pixel)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out <= pixel;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_alpha        = r_out.alpha;
    assign o_format_error = r_out.format_error;

    `TFR_ASSERT(a_conv_enters_s1, i_clk, i_rst_n, conv_beat |=> r_s1_valid, "convert beat lost")
    `TFR_ASSERT(a_write_no_result, i_clk, i_rst_n, (in_accept && (i_command == CMD_PAL_WRITE)) |=> !r_s1_valid, "palette write gave a result")
    `TFR_ASSERT(a_error_zero, i_clk, i_rst_n, (o_out_valid && o_format_error) |-> ((o_red | o_green | o_blue | o_alpha) == 8'd0), "format error, channels not zero")
    `TFR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_out_valid && !r_s1_valid), "pipeline not empty after reset")

endmodule
